FILE: rtl/lpht_pkg.sv
// Package: shared constants and types for the linear probe hash table.
`timescale 1ns / 1ps
package lpht_pkg;
  localparam int CAPACITY_DEF      = 1024;
  localparam int MAX_KEY_CHARS_DEF = 8;
  localparam int SIZE_W            = 11;
  localparam int KEY_W             = 64;
  localparam int LEN_W             = 4;
  localparam logic [SIZE_W-1:0] DEFAULT_SIZE = 11'd11;
  localparam logic [SIZE_W-1:0] COUNT_MAX    = 11'd2047;
  localparam logic [4:0]        HASH_BASE    = 5'd26;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_DEL   = 2'd2,
    TAG_BAD   = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;
endpackage

FILE: rtl/linear_probe_hash_table.sv
// Top level: open-addressing hash table with linear probing over slot memories.
`timescale 1ns / 1ps
// One request at a time. The request is accepted in the idle cycle. Each modulo reduction
// of the hash is a restoring division by table_size. One reduction handles the start
// value 26, and each key byte then takes one multiply-add step and one more reduction.
// Every probed slot goes through the synchronous slot memories in a read state, then a
// check state that checks and writes back, and the result is held until out_stall is low.
// A request of the unused kind does no probing. The slot tags are swept to empty after
// reset, one slot a cycle, and no request is taken during the sweep.
module linear_probe_hash_table #(
  parameter int CAPACITY      = lpht_pkg::CAPACITY_DEF,
  parameter int MAX_KEY_CHARS = lpht_pkg::MAX_KEY_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic [lpht_pkg::KEY_W-1:0] in_key_bytes,
  input  logic [lpht_pkg::LEN_W-1:0] in_key_length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [lpht_pkg::SIZE_W-1:0] out_slot_index,
  output logic [lpht_pkg::SIZE_W-1:0] out_item_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lpht_pkg::SIZE_W-1:0] cfg_data
);
  import lpht_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SIZE_W-1:0] CAP_V = SIZE_W'(CAPACITY);
  localparam logic [LEN_W-1:0]  MAXC  = LEN_W'(MAX_KEY_CHARS);
  // h < size <= 1024, c*c <= 65025: partial value fits in 18 bits.
  localparam int PW = 18;
  // The partial value stays below 2^17, which is at most size << 16, so 16 shifts suffice.
  localparam int SHIFTS = 16;
  localparam int DW = SIZE_W + SHIFTS - 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_RED   = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]        tag_mem [CAPACITY];
  logic [KEY_W-1:0]  key_mem [CAPACITY];
  logic [LEN_W-1:0]  len_mem [CAPACITY];

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] count_r;
  logic [1:0]        kind_r;
  logic [KEY_W-1:0]  key_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  byte_r;
  logic [PW-1:0]     part_r;
  logic [3:0]        shift_r;
  logic [SIZE_W-1:0] pos_r;
  logic [SIZE_W-1:0] probes_r;
  logic [AW-1:0]     clr_r;
  logic [1:0]        rd_tag_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [1:0]        status_r;
  logic [SIZE_W-1:0] slot_r;

  logic              in_acc;
  logic [LEN_W-1:0]  len_clip;
  logic [KEY_W-1:0]  key_mask;
  logic [7:0]        cur_byte;
  logic [PW-1:0]     hash_step;
  logic [DW-1:0]     div_term;
  logic [PW-1:0]     part_red;
  logic [SIZE_W-1:0] pos_inc;
  logic              wr_en;
  logic [1:0]        wr_tag;
  logic              key_wr;
  logic              cnt_inc;
  logic              key_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign out_slot_index = slot_r;
  assign out_item_count = count_r;

  assign len_clip = (in_key_length > MAXC) ? MAXC : in_key_length;
  always_comb begin
    key_mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (LEN_W'(i) < len_clip) key_mask[i*8 +: 8] = 8'hFF;
    end
  end

  assign cur_byte  = key_r[{byte_r[2:0], 3'b000} +: 8];
  assign hash_step = PW'(part_r[SIZE_W-1:0]) * PW'(HASH_BASE) + PW'(cur_byte) * PW'(cur_byte);
  assign div_term  = DW'(size_r) << shift_r;
  assign part_red  = (DW'(part_r) >= div_term) ? PW'(DW'(part_r) - div_term) : part_r;
  assign pos_inc   = (pos_r + 1'b1 >= size_r) ? '0 : pos_r + 1'b1;
  assign key_hit   = (rd_tag_r == TAG_USED) && (rd_len_r == len_r) && (rd_key_r == key_r);

  always_comb begin
    state_nxt = state_r;
    wr_en = 1'b0;
    wr_tag = TAG_EMPTY;
    key_wr = 1'b0;
    cnt_inc = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_r == AW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE:  if (in_acc) state_nxt = S_RED;
      S_HASH:  state_nxt = S_RED;
      S_RED: begin
        // Finish the reduction, then take the next byte, start probing, or go to output for the unused kind.
        if (shift_r != '0) state_nxt = S_RED;
        else if (byte_r < len_r) state_nxt = S_HASH;
        else if (kind_r == KIND_NONE) state_nxt = S_OUT;
        else state_nxt = S_READ;
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (kind_r == KIND_INSERT) begin
          if (rd_tag_r != TAG_USED) begin
            wr_en = 1'b1; wr_tag = TAG_USED; key_wr = 1'b1; cnt_inc = 1'b1;
            state_nxt = S_OUT;
          end
        end else if (rd_tag_r == TAG_EMPTY) begin
          state_nxt = S_OUT;
        end else if (key_hit) begin
          if (kind_r == KIND_REMOVE) begin
            wr_en = 1'b1; wr_tag = TAG_DEL;
          end
          state_nxt = S_OUT;
        end
        if (state_nxt == S_CHECK) begin
          state_nxt = (probes_r + 1'b1 >= size_r) ? S_OUT : S_READ;
        end
      end
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      size_r  <= DEFAULT_SIZE;
      count_r <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_data < SIZE_W'(2)) size_r <= SIZE_W'(2);
        else if (cfg_data > CAP_V) size_r <= CAP_V;
        else size_r <= cfg_data;
      end
      if (cnt_inc && count_r != COUNT_MAX) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        kind_r   <= in_kind;
        key_r    <= in_key_bytes & key_mask;
        len_r    <= len_clip;
        byte_r   <= '0;
        part_r   <= PW'(HASH_BASE);
        shift_r  <= 4'(SHIFTS - 1);
        probes_r <= '0;
        status_r <= ST_MISS;
        slot_r   <= size_r;
      end
      S_HASH: begin
        part_r  <= hash_step;
        byte_r  <= byte_r + 1'b1;
        shift_r <= 4'(SHIFTS - 1);
      end
      S_RED: begin
        part_r  <= part_red;
        shift_r <= shift_r - 1'b1;
        if (shift_r == '0) begin
          pos_r <= part_red[SIZE_W-1:0];
          if (byte_r >= len_r && kind_r == KIND_INSERT) status_r <= ST_FULL;
        end
      end
      S_CHECK: begin
        pos_r    <= pos_inc;
        probes_r <= probes_r + 1'b1;
        if (kind_r == KIND_INSERT) begin
          if (rd_tag_r != TAG_USED) begin
            status_r <= ST_DONE; slot_r <= pos_r;
          end
        end else if (rd_tag_r != TAG_EMPTY && key_hit) begin
          status_r <= ST_DONE; slot_r <= pos_r;
        end
      end
      default: ;
    endcase
  end

  // Slot memories: one read port, one write port, registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) tag_mem[(state_r == S_CLEAR) ? clr_r : pos_r[AW-1:0]] <= wr_tag;
    if (key_wr) begin
      key_mem[pos_r[AW-1:0]] <= key_r;
      len_mem[pos_r[AW-1:0]] <= len_r;
    end
    rd_tag_r <= tag_mem[pos_r[AW-1:0]];
    rd_key_r <= key_mem[pos_r[AW-1:0]];
    rd_len_r <= len_mem[pos_r[AW-1:0]];
  end
endmodule
